// File: rtl/telemetry_report_scheduler_defines.svh
// Assertion macros for the telemetry report scheduler.
`ifndef TELEMETRY_REPORT_SCHEDULER_DEFINES_SVH
`define TELEMETRY_REPORT_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define TRS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("trs assertion failed");

// Checked on every edge, reset included.
`define TRS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("trs assertion failed");

`else

`define TRS_ASSERT(label, clk, rst_n, prop)
`define TRS_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// File: rtl/trs_pkg.sv
// Types and constants for the telemetry report scheduler.
`timescale 1ns / 1ps
`default_nettype none

package trs_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_HEALTH = 2'd1,
        FUNC_RELAY  = 2'd2,
        FUNC_MANUAL = 2'd3
    } func_t;

    localparam int PERIOD_W   = 27;
    localparam int LIMIT_W    = 8;
    localparam int CFG_DATA_W = 27;
    localparam int MS_W       = 10;
    localparam int CNT_W      = 32;
    localparam int FAIL_W     = 8;
    localparam int RELAY_W    = 16;
    localparam int NUM_DEV    = 3;
    localparam int S_TUSER_W  = 2;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 72;

    localparam logic CFG_IDX_PERIOD = 1'b0;
    localparam logic CFG_IDX_LIMIT  = 1'b1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = PERIOD_W'(10000);
    localparam logic [PERIOD_W-1:0] MIN_PERIOD_MS = PERIOD_W'(1000);
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET   = LIMIT_W'(3);
    localparam logic [MS_W-1:0]     MS_PER_SECOND = MS_W'(1000);
    localparam logic [RELAY_W-1:0]  RELAY_UNKNOWN = 16'hFFFF;
    localparam logic [FAIL_W-1:0]   FAIL_MAX      = 8'hFF;
    localparam logic [CNT_W-1:0]    ELAPSED_MAX   = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// File: rtl/telemetry_report_scheduler.sv
// Telemetry report scheduler: report trigger with device health tracking.
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+------------------------------------
//  s_       | in  | s_tvalid / s_tready   | s_tuser: func; s_tdata: link, ok bits, relay
//  m_       | out | m_tvalid / m_tready   | m_tdata: fire, seq, seconds, status, event
//  cfg_     | in  | cfg_we                | cfg_addr, cfg_wdata
//
// One request per cycle while s_tready is high; each request is fully evaluated in the accept cycle
// and its result is loaded into the output register at the accepting edge.
// s_tready stays high while the output register is empty or being drained.
// aresetn is synchronous; no clearing pass, the block is ready right after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "telemetry_report_scheduler_defines.svh"

module telemetry_report_scheduler (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [1:0] func
    input  wire logic [trs_pkg::S_TUSER_W-1:0]   s_tuser,
    // [0] link_idle, [1] temp_sensor_ok, [2] scale_ok,
    // [3] relay_unit_ok, [19:4] relay_outputs, [23:20] zero
    input  wire logic [trs_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [0] report_fire, [32:1] report_seq, [64:33] report_seconds,
    // [67:65] status_bits, [68] event_waiting, [71:69] zero
    output logic [trs_pkg::M_TDATA_W-1:0]        m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_addr,
    input  wire logic [trs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import trs_pkg::*;

    logic [PERIOD_W-1:0] period_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    logic [MS_W-1:0]     ms_reg,       ms_next;
    logic [CNT_W-1:0]    sec_reg,      sec_next;
    logic [CNT_W-1:0]    elapsed_reg,  elapsed_next;
    logic [CNT_W-1:0]    seq_reg,      seq_next;
    logic                pending_reg,  pending_next;
    logic [NUM_DEV-1:0]  offline_reg,  offline_next;
    logic [FAIL_W-1:0]   fail_reg      [NUM_DEV];
    logic [FAIL_W-1:0]   fail_next     [NUM_DEV];
    logic [RELAY_W-1:0]  relay_reg,    relay_next;
    logic                fire_next;

    logic                out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                s_acc;
    func_t               in_func;
    logic                in_idle;
    logic [NUM_DEV-1:0]  in_ok;
    logic [RELAY_W-1:0]  in_relay;
    logic [MS_W-1:0]     ms_inc;
    logic [CNT_W-1:0]    elapsed_inc;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign in_func  = func_t'(s_tuser);
    assign in_idle  = s_tdata[0];
    assign in_ok    = s_tdata[3:1];
    assign in_relay = s_tdata[19:4];

    assign ms_inc      = ms_reg + MS_W'(1);
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + CNT_W'(1);

    always_comb begin
        ms_next      = ms_reg;
        sec_next     = sec_reg;
        elapsed_next = elapsed_reg;
        seq_next     = seq_reg;
        pending_next = pending_reg;
        offline_next = offline_reg;
        relay_next   = relay_reg;
        fire_next    = 1'b0;
        for (int i = 0; i < NUM_DEV; i++) begin
            fail_next[i] = fail_reg[i];
        end

        unique case (in_func)
            FUNC_TICK: begin
                if (ms_inc >= MS_PER_SECOND) begin
                    ms_next  = '0;
                    sec_next = sec_reg + CNT_W'(1);
                end else begin
                    ms_next = ms_inc;
                end
                elapsed_next = elapsed_inc;
                if (in_idle) begin
                    if (pending_reg) begin
                        pending_next = 1'b0;
                        fire_next    = 1'b1;
                    end else if (elapsed_inc >= CNT_W'(period_reg)) begin
                        fire_next = 1'b1;
                    end
                end
                if (fire_next) begin
                    seq_next     = seq_reg + CNT_W'(1);
                    elapsed_next = '0;
                end
            end
            FUNC_HEALTH: begin
                for (int i = 0; i < NUM_DEV; i++) begin
                    if (in_ok[i]) begin
                        fail_next[i]    = '0;
                        offline_next[i] = 1'b0;
                    end else begin
                        fail_next[i] = (fail_reg[i] == FAIL_MAX) ? FAIL_MAX
                                                                 : fail_reg[i] + FAIL_W'(1);
                        if (fail_next[i] >= limit_reg) begin
                            offline_next[i] = 1'b1;
                        end
                    end
                end
                if (offline_next != offline_reg) begin
                    pending_next = 1'b1;
                end
            end
            FUNC_RELAY: begin
                if (relay_reg != RELAY_UNKNOWN && relay_reg != in_relay) begin
                    pending_next = 1'b1;
                end
                relay_next = in_relay;
            end
            FUNC_MANUAL: begin
                pending_next = 1'b1;
            end
            default: begin
            end
        endcase

        out_data_next = {3'b000, pending_next, offline_next, sec_next, seq_next, fire_next};
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= PERIOD_RESET;
            limit_reg  <= LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_IDX_PERIOD: begin
                    if (cfg_wdata[PERIOD_W-1:0] >= MIN_PERIOD_MS) begin
                        period_reg <= cfg_wdata[PERIOD_W-1:0];
                    end
                end
                CFG_IDX_LIMIT: begin
                    limit_reg <= cfg_wdata[LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // scheduler state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_reg      <= '0;
            sec_reg     <= '0;
            elapsed_reg <= '0;
            seq_reg     <= '0;
            pending_reg <= 1'b0;
            offline_reg <= '0;
            relay_reg   <= RELAY_UNKNOWN;
            for (int i = 0; i < NUM_DEV; i++) begin
                fail_reg[i] <= '0;
            end
        end else if (s_acc) begin
            ms_reg      <= ms_next;
            sec_reg     <= sec_next;
            elapsed_reg <= elapsed_next;
            seq_reg     <= seq_next;
            pending_reg <= pending_next;
            offline_reg <= offline_next;
            relay_reg   <= relay_next;
            for (int i = 0; i < NUM_DEV; i++) begin
                fail_reg[i] <= fail_next[i];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_acc) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            out_data_reg <= out_data_next;
        end
    end

    // assertions
    `TRS_ASSERT(a_seq_only_on_idle_tick, aclk, aresetn, (s_acc && !(in_func == FUNC_TICK && in_idle)) |=> (seq_reg == $past(seq_reg)))
    `TRS_ASSERT(a_fire_clears_elapsed, aclk, aresetn, (s_acc && fire_next) |=> (elapsed_reg == '0 && out_data_reg[0]))
    `TRS_ASSERT(a_manual_sets_pending, aclk, aresetn, (s_acc && in_func == FUNC_MANUAL) |=> pending_reg)
    `TRS_ASSERT_ALWAYS(a_ms_in_range, aclk, !aresetn || ms_reg < MS_PER_SECOND)
    `TRS_ASSERT(a_offline_has_failures, aclk, aresetn, (offline_reg & ~{fail_reg[2] != '0, fail_reg[1] != '0, fail_reg[0] != '0}) == '0)

endmodule

`default_nettype wire
